// ----- rtl/tgbp_pkg.sv -----
`timescale 1ns / 1ps
package tgbp_pkg;

  localparam int NUM_TABLES      = 11;
  localparam int TABLE_ENTRIES   = 1024;
  localparam int IDX_BITS        = $clog2(TABLE_ENTRIES);
  localparam int BASE_INDEX_BITS = 13;
  localparam int BASE_DEPTH      = 2 ** BASE_INDEX_BITS;
  localparam int TAG_BITS        = 15;
  localparam int MAX_HISTORY     = 640;
  localparam int AGING_PERIOD    = 262144;
  localparam int PC_W            = 32;
  localparam int PATH_W          = 5;
  localparam int PROV_W          = $clog2(NUM_TABLES + 1);
  localparam int SEED_W          = 16;
  localparam int CTR_W           = 3;
  localparam int USE_W           = 2;
  localparam int BASE_W          = 2;
  localparam int PREF_W          = 4;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;
  localparam int TICK_W          = $clog2(AGING_PERIOD + 1);
  localparam int CLR_N           = (BASE_DEPTH > TABLE_ENTRIES) ? BASE_DEPTH : TABLE_ENTRIES;
  localparam int CNT_W           = $clog2(CLR_N + 1);

  localparam int GEO_LEN [16] = '{640, 403, 254, 160, 101, 64, 40, 25, 16, 10, 6,
                                  5, 4, 3, 2, 1};

  // remainder by reciprocal multiplication
  localparam int MOD_SH   = 23;
  localparam int M_TABLES = (2 ** MOD_SH + NUM_TABLES - 1) / NUM_TABLES;
  localparam int M_PCT    = (2 ** MOD_SH + 99) / 100;
  localparam int PCT      = 100;

  localparam logic [CTR_W-1:0]  CTR_MAX   = '1;
  localparam logic [CTR_W-1:0]  CTR_WEAKT = CTR_W'(4);
  localparam logic [CTR_W-1:0]  CTR_WEAKN = CTR_W'(3);
  localparam logic [USE_W-1:0]  USE_MAX   = '1;
  localparam logic [BASE_W-1:0] BASE_MAX  = '1;
  localparam logic [BASE_W-1:0] BASE_INIT = BASE_W'(2);
  localparam logic [PREF_W-1:0] PREF_MAX  = '1;
  localparam logic [PREF_W-1:0] PREF_INIT = PREF_W'(8);

  localparam logic [APB_AW-3:0] REG_SEED = '0;

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef struct packed {
    logic [CTR_W-1:0]    ctr;
    logic [TAG_BITS-1:0] tag;
    logic [USE_W-1:0]    u;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic taken;
  } hist_upd_t;

  function automatic int tab_tag_w(input int t);
    return (t == NUM_TABLES - 1) ? TAG_BITS - 1 : TAG_BITS;
  endfunction

  // 99 / (d + 1)
  function automatic logic [6:0] alloc_thr(input logic [4:0] d);
    logic [6:0] r;
    case (d)
      5'd1:    r = 7'd49;
      5'd2:    r = 7'd33;
      5'd3:    r = 7'd24;
      5'd4:    r = 7'd19;
      5'd5:    r = 7'd16;
      5'd6:    r = 7'd14;
      5'd7:    r = 7'd12;
      5'd8:    r = 7'd11;
      5'd9:    r = 7'd9;
      5'd10:   r = 7'd9;
      5'd11:   r = 7'd8;
      5'd12:   r = 7'd7;
      5'd13:   r = 7'd7;
      5'd14:   r = 7'd6;
      5'd15:   r = 7'd6;
      5'd16:   r = 7'd5;
      default: r = 7'd99;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tgbp_in_if.sv -----
`timescale 1ns / 1ps
interface tgbp_in_if;
  import tgbp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] pc;
  logic            taken;
  modport source (output valid, pc, taken, input ready);
  modport sink (input valid, pc, taken, output ready);
endinterface

// ----- rtl/tgbp_out_if.sv -----
`timescale 1ns / 1ps
interface tgbp_out_if;
  import tgbp_pkg::*;
  logic              valid;
  logic              ready;
  logic              predicted_taken;
  logic [PROV_W-1:0] provider_index;
  logic              used_alternate;
  modport source (output valid, predicted_taken, provider_index, used_alternate, input ready);
  modport sink (input valid, predicted_taken, provider_index, used_alternate, output ready);
endinterface

// ----- rtl/tgbp_ram.sv -----
`timescale 1ns / 1ps
module tgbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/tgbp_hist.sv -----
`timescale 1ns / 1ps
module tgbp_hist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tgbp_pkg::PC_W-1:0]   pc_i,
  input  tgbp_pkg::hist_upd_t         upd_i,
  output tgbp_pkg::idx_t              idx_o [tgbp_pkg::NUM_TABLES],
  output tgbp_pkg::tag_t              tag_o [tgbp_pkg::NUM_TABLES]
);
  import tgbp_pkg::*;

  logic [MAX_HISTORY-1:0] ghist_q, ghist_d;
  logic [PATH_W-1:0]      path_q, path_d;

  assign ghist_d = {ghist_q[MAX_HISTORY-2:0], upd_i.taken};
  assign path_d  = {path_q[PATH_W-2:0], upd_i.taken};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ghist_q <= '0;
      path_q  <= '0;
    end else if (upd_i.valid) begin
      ghist_q <= ghist_d;
      path_q  <= path_d;
    end
  end

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tab
    localparam int W    = tab_tag_w(t);
    localparam int LEN  = (GEO_LEN[t] > MAX_HISTORY) ? MAX_HISTORY : GEO_LEN[t];
    localparam int SI   = LEN % IDX_BITS;
    localparam int SA   = LEN % W;
    localparam int SB   = LEN % (W - 1);
    localparam int SH   = NUM_TABLES - 1 - t;
    localparam logic [TAG_BITS-1:0] MASK_A = TAG_BITS'((2 ** W) - 1);
    localparam logic [TAG_BITS-1:0] MASK_B = TAG_BITS'((2 ** (W - 1)) - 1);

    logic [IDX_BITS-1:0] fi_q, fi_d;
    logic [TAG_BITS-1:0] fa_q, fa_d, fb_q, fb_d;
    logic [IDX_BITS:0]   fi1;
    logic [TAG_BITS:0]   fa1, fb1;
    logic [PC_W-1:0]     pc_sh;

    always_comb begin
      fi1 = {fi_q, upd_i.taken};
      fi1[SI] = fi1[SI] ^ ghist_q[LEN-1];
      fi_d = fi1[IDX_BITS-1:0] ^ IDX_BITS'(fi1[IDX_BITS]);
      fa1 = {fa_q, upd_i.taken};
      fa1[SA] = fa1[SA] ^ ghist_q[LEN-1];
      fa_d = TAG_BITS'(fa1 ^ (fa1 >> W)) & MASK_A;
      fb1 = {fb_q, upd_i.taken};
      fb1[SB] = fb1[SB] ^ ghist_q[LEN-1];
      fb_d = TAG_BITS'(fb1 ^ (fb1 >> (W - 1))) & MASK_B;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fi_q <= '0;
        fa_q <= '0;
        fb_q <= '0;
      end else if (upd_i.valid) begin
        fi_q <= fi_d;
        fa_q <= fa_d;
        fb_q <= fb_d;
      end
    end

    assign pc_sh    = pc_i >> SH;
    assign idx_o[t] = pc_i[IDX_BITS-1:0] ^ pc_sh[IDX_BITS-1:0] ^ fi_q
                      ^ IDX_BITS'(path_q >> SH);
    assign tag_o[t] = (pc_i[TAG_BITS-1:0] ^ fa_q ^ TAG_BITS'({fb_q, 1'b0})) & MASK_A;
  end

endmodule

// ----- rtl/tagged_geometric_branch_predictor_unit.sv -----
`timescale 1ns / 1ps
// channel | dir | payload                                        | transfer
// br_i    | in  | pc[31:0], taken                                | valid & ready
// res_o   | out | predicted_taken, provider_index[3:0], used_alt | valid & ready
// apb     | in  | random_seed at 0x0                             | psel & penable
//
// Per branch: table read, then decide and write back all tagged banks.
// After reset a sweep clears all base and table entries before br_i is ready.
// Every 262144 branches a useful-bit aging sweep of the tables holds br_i.
// A result not yet taken holds the next write-back in the decide cycle.
module tagged_geometric_branch_predictor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tgbp_in_if.sink                             br_i,
  tgbp_out_if.source                          res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tgbp_pkg::APB_AW-1:0]         paddr,
  input  logic [tgbp_pkg::APB_DW-1:0]         pwdata,
  output logic [tgbp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import tgbp_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_AGE   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic                phase_q, phase_d;
  logic                keep_lo_q, keep_lo_d;
  logic [PREF_W-1:0]   pref_q, pref_d;
  logic [SEED_W-1:0]   seed_q;
  logic [SEED_W-1:0]   lfsr_q, lfsr_d;
  logic                taken_q;
  logic [BASE_INDEX_BITS-1:0] bidx_q;
  idx_t                idx_q [NUM_TABLES];
  tag_t                tag_q [NUM_TABLES];
  idx_t                hidx  [NUM_TABLES];
  tag_t                htag  [NUM_TABLES];

  logic                res_valid_q;
  logic                res_pred_q;
  logic [PROV_W-1:0]   res_prov_q;
  logic                res_alt_q;

  logic                in_fire, look_go, cfg_wr;
  hist_upd_t           hupd;

  // memory ports
  logic                tre, twe;
  idx_t                traddr, twaddr;
  entry_t              twdata [NUM_TABLES];
  logic [$bits(entry_t)-1:0] trd [NUM_TABLES];
  entry_t              rd [NUM_TABLES];
  logic                bre, bwe;
  logic [BASE_INDEX_BITS-1:0] bwaddr;
  logic [BASE_W-1:0]   bwdata, brd;

  // decision
  logic [PROV_W-1:0]   prov, alt;
  logic                prov_v, alt_v, base_dir, prov_pred, alt_dir, pred, use_alt;
  logic                alloc_en, found, low_conf, alt_win;
  logic                lbit;
  logic [SEED_W-1:0]   rnd;
  logic [SEED_W+MOD_SH:0] p11, p100;
  logic [SEED_W-1:0]   q11, q100, r11, r100;
  entry_t              ent1 [NUM_TABLES];
  entry_t              pe, ae, pn, an;
  logic [USE_W-1:0]    au1;
  logic [BASE_W-1:0]   bnew;

  tgbp_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pc_i   (br_i.pc),
    .upd_i  (hupd),
    .idx_o  (hidx),
    .tag_o  (htag)
  );

  assign br_i.ready = (state_q == ST_IDLE);
  assign in_fire    = br_i.valid && br_i.ready;
  assign look_go    = (state_q == ST_LOOK) && (!res_valid_q || res_o.ready);
  assign hupd.valid = look_go;
  assign hupd.taken = taken_q;

  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_SEED);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_SEED) ? APB_DW'(seed_q) : '0;

  // read and write addressing
  always_comb begin
    tre    = 1'b0;
    traddr = hidx[0];
    twe    = 1'b0;
    twaddr = cnt_q[IDX_BITS-1:0];
    bre    = in_fire;
    bwe    = 1'b0;
    bwaddr = bidx_q;
    bwdata = bnew;
    if (state_q == ST_IDLE) begin
      tre = in_fire;
    end else if (state_q == ST_AGE) begin
      tre    = (cnt_q < CNT_W'(TABLE_ENTRIES));
      traddr = cnt_q[IDX_BITS-1:0];
      twe    = (cnt_q != '0);
      twaddr = IDX_BITS'(cnt_q - CNT_W'(1));
    end else if (state_q == ST_CLEAR) begin
      twe    = 1'b1;
      bwe    = 1'b1;
      bwaddr = cnt_q[BASE_INDEX_BITS-1:0];
      bwdata = BASE_INIT;
    end else begin
      twe = look_go;
      bwe = look_go && !prov_v;
    end
  end

  for (genvar t = 0; t < NUM_TABLES; t++) begin : g_bank
    idx_t ra, wa;
    assign ra    = (state_q == ST_IDLE) ? hidx[t] : traddr;
    assign wa    = (state_q == ST_LOOK) ? idx_q[t] : twaddr;
    assign rd[t] = entry_t'(trd[t]);
    tgbp_ram #(
      .WIDTH ($bits(entry_t)),
      .DEPTH (TABLE_ENTRIES)
    ) u_tab (
      .clk_i   (clk_i),
      .we_i    (twe),
      .waddr_i (wa),
      .wdata_i (twdata[t]),
      .re_i    (tre),
      .raddr_i (ra),
      .rdata_o (trd[t])
    );
  end

  tgbp_ram #(
    .WIDTH (BASE_W),
    .DEPTH (BASE_DEPTH)
  ) u_base (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (bwaddr),
    .wdata_i (bwdata),
    .re_i    (bre),
    .raddr_i (br_i.pc[BASE_INDEX_BITS-1:0]),
    .rdata_o (brd)
  );

  // lookup and update
  always_comb begin
    prov = PROV_W'(NUM_TABLES);
    alt  = PROV_W'(NUM_TABLES);
    for (int t = NUM_TABLES - 1; t >= 0; t--) begin
      if (rd[t].tag == tag_q[t]) prov = PROV_W'(t);
    end
    for (int t = NUM_TABLES - 1; t >= 0; t--) begin
      if (rd[t].tag == tag_q[t] && PROV_W'(t) > prov) alt = PROV_W'(t);
    end
    prov_v = (prov != PROV_W'(NUM_TABLES));
    alt_v  = (alt != PROV_W'(NUM_TABLES));
    pe = '0;
    ae = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (PROV_W'(t) == prov) pe = rd[t];
      if (PROV_W'(t) == alt) ae = rd[t];
    end
    base_dir  = brd[BASE_W-1];
    alt_dir   = alt_v ? (ae.ctr > CTR_WEAKN) : base_dir;
    prov_pred = pe.ctr > CTR_WEAKN;
    use_alt   = prov_v && (pe.ctr == CTR_WEAKN || pe.ctr == CTR_WEAKT) && (pe.u == '0)
                && pref_q[PREF_W-1];
    pred      = prov_v ? (use_alt ? alt_dir : prov_pred) : base_dir;

    // allocation draw
    alloc_en = (prov != '0) && (pred != taken_q);
    found    = 1'b0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (PROV_W'(t) < prov && rd[t].u == '0) found = 1'b1;
    end
    lbit = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    rnd  = {lbit, lfsr_q[SEED_W-1:1]};
    p11  = (SEED_W+MOD_SH+1)'(rnd) * (SEED_W+MOD_SH+1)'(M_TABLES);
    p100 = (SEED_W+MOD_SH+1)'(rnd) * (SEED_W+MOD_SH+1)'(M_PCT);
    q11  = p11[MOD_SH +: SEED_W];
    q100 = p100[MOD_SH +: SEED_W];
    r11  = rnd - SEED_W'(q11 * SEED_W'(NUM_TABLES));
    r100 = rnd - SEED_W'(q100 * SEED_W'(PCT));
    lfsr_d = alloc_en ? rnd : lfsr_q;

    for (int t = 0; t < NUM_TABLES; t++) begin
      ent1[t] = rd[t];
      if (alloc_en && (found ? (PROV_W'(t) < prov && rd[t].u == '0
                                && r100 <= SEED_W'(alloc_thr(5'(prov) - 5'(t))))
                             : (r11 == SEED_W'(t)))) begin
        ent1[t].ctr = taken_q ? CTR_WEAKT : CTR_WEAKN;
        ent1[t].tag = tag_q[t];
        ent1[t].u   = '0;
      end
    end

    pn = '0;
    an = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (PROV_W'(t) == prov) pn = ent1[t];
      if (PROV_W'(t) == alt) an = ent1[t];
    end
    if (taken_q) begin
      if (pn.ctr != CTR_MAX) pn.ctr = pn.ctr + CTR_W'(1);
    end else if (pn.ctr != '0) begin
      pn.ctr = pn.ctr - CTR_W'(1);
    end
    if (prov_pred == taken_q) begin
      if (pn.u != USE_MAX) pn.u = pn.u + USE_W'(1);
    end else if (pn.u != '0) begin
      pn.u = pn.u - USE_W'(1);
    end
    low_conf = prov_v && (pn.ctr == CTR_WEAKN || pn.ctr == CTR_WEAKT) && (pn.u == '0);
    alt_win  = (alt_dir == taken_q) && (prov_pred != taken_q);
    pref_d   = pref_q;
    au1      = an.u;
    if (low_conf) begin
      if (alt_win) begin
        if (pref_q != PREF_MAX) pref_d = pref_q + PREF_W'(1);
        if (taken_q) begin
          if (au1 != USE_MAX) au1 = au1 + USE_W'(1);
        end else if (au1 != '0) begin
          au1 = au1 - USE_W'(1);
        end
        if (au1 != USE_MAX) au1 = au1 + USE_W'(1);
      end else begin
        if (pref_q != '0) pref_d = pref_q - PREF_W'(1);
        if (au1 != '0) au1 = au1 - USE_W'(1);
      end
    end
    an.u = au1;

    bnew = brd;
    if (taken_q) begin
      if (brd != BASE_MAX) bnew = brd + BASE_W'(1);
    end else if (brd != '0) begin
      bnew = brd - BASE_W'(1);
    end

    for (int t = 0; t < NUM_TABLES; t++) begin
      if (state_q == ST_CLEAR) begin
        twdata[t] = '0;
      end else if (state_q == ST_AGE) begin
        twdata[t] = rd[t];
        if (keep_lo_q) twdata[t].u[1] = 1'b0;
        else twdata[t].u[0] = 1'b0;
      end else if (PROV_W'(t) == prov) begin
        twdata[t] = pn;
      end else if (PROV_W'(t) == alt && low_conf) begin
        twdata[t] = an;
      end else begin
        twdata[t] = ent1[t];
      end
    end
  end

  // sequencing
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    keep_lo_d = keep_lo_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (look_go) begin
          state_d = ST_IDLE;
          tick_d  = tick_q + TICK_W'(1);
          if (tick_d == TICK_W'(AGING_PERIOD)) begin
            tick_d    = '0;
            state_d   = ST_AGE;
            cnt_d     = '0;
            keep_lo_d = phase_q;
            phase_d   = !phase_q;
          end
        end
      end
      ST_AGE: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      tick_q      <= '0;
      phase_q     <= 1'b1;
      keep_lo_q   <= 1'b1;
      pref_q      <= PREF_INIT;
      seed_q      <= SEED_W'(1);
      lfsr_q      <= SEED_W'(1);
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      tick_q    <= tick_d;
      phase_q   <= phase_d;
      keep_lo_q <= keep_lo_d;
      if (look_go) begin
        pref_q      <= pref_d;
        lfsr_q      <= lfsr_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        seed_q <= pwdata[SEED_W-1:0];
        lfsr_q <= (pwdata[SEED_W-1:0] == '0) ? SEED_W'(1) : pwdata[SEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      taken_q <= br_i.taken;
      bidx_q  <= br_i.pc[BASE_INDEX_BITS-1:0];
      idx_q   <= hidx;
      tag_q   <= htag;
    end
    if (look_go) begin
      res_pred_q <= pred;
      res_prov_q <= prov;
      res_alt_q  <= use_alt;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.predicted_taken = res_pred_q;
  assign res_o.provider_index  = res_prov_q;
  assign res_o.used_alternate  = res_alt_q;

endmodule
